// ===== src/stereo_param_unpacker_core_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros for the stereo parameter unpacker
// Shared concurrent assertion forms, clocked on clk and held off in reset.
// ----------------------------------------------------------------------------
`ifndef STEREO_PARAM_UNPACKER_CORE_MACROS_SVH
`define STEREO_PARAM_UNPACKER_CORE_MACROS_SVH

// Same-cycle implication.
`define SPU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define SPU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/spu_pkg.sv =====
// ----------------------------------------------------------------------------
// spu_pkg
// Types, result codes and dequantisation tables of the stereo parameter unpacker.
// ----------------------------------------------------------------------------
`default_nettype none

package spu_pkg;

    // Largest band count accepted in a header.
    localparam int MAX_BANDS = 20;

    // Depth of the queue between the front and back parts, in bundles.
    localparam int QUEUE_DEPTH = 2;
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

    // Result item types.
    localparam logic [2:0] ITEM_HEADER    = 3'd0;
    localparam logic [2:0] ITEM_INTENSITY = 3'd1;
    localparam logic [2:0] ITEM_COHERENCE = 3'd2;
    localparam logic [2:0] ITEM_PHASE     = 3'd3;
    localparam logic [2:0] ITEM_ERROR     = 3'd4;
    localparam logic [2:0] ITEM_COMPLETE  = 3'd5;

    // Fault codes.
    localparam logic [1:0] FAULT_NONE      = 2'd0;
    localparam logic [1:0] FAULT_BAD_BANDS = 2'd1;
    localparam logic [1:0] FAULT_TRUNCATED = 2'd2;

    // One result as classified by the front part.
    typedef struct packed {
        logic [2:0] item_type;
        logic [4:0] band;
        logic [4:0] code;
        logic [1:0] fault;
    } entry_t;

    // All results caused by one input item.
    typedef struct packed {
        entry_t [3:0] ent;
        logic [2:0]   count;
        logic [4:0]   band_total;
        logic         phase_flag;
    } bundle_t;

    // Queue status seen by both sides.
    typedef struct packed {
        logic full;
        logic empty;
    } qstat_t;

    // Magnitude of the intensity level for codes 16 + j, Q12.
    function automatic logic [15:0] intensity_mag(input logic [3:0] j);
        logic [15:0] m;
        case (j)
            4'd0:    m = 16'd1982;
            4'd1:    m = 16'd5946;
            4'd2:    m = 16'd9910;
            4'd3:    m = 16'd13874;
            4'd4:    m = 16'd17837;
            4'd5:    m = 16'd21801;
            4'd6:    m = 16'd25765;
            4'd7:    m = 16'd29729;
            4'd8:    m = 16'd33693;
            4'd9:    m = 16'd37657;
            4'd10:   m = 16'd41621;
            4'd11:   m = 16'd45585;
            4'd12:   m = 16'd49548;
            4'd13:   m = 16'd53512;
            4'd14:   m = 16'd57476;
            default: m = 16'd61440;
        endcase
        return m;
    endfunction

    // Coherence ratio q / 7 in Q12.
    function automatic logic [15:0] coherence_val(input logic [2:0] q);
        logic [15:0] m;
        case (q)
            3'd0:    m = 16'd0;
            3'd1:    m = 16'd585;
            3'd2:    m = 16'd1170;
            3'd3:    m = 16'd1755;
            3'd4:    m = 16'd2341;
            3'd5:    m = 16'd2926;
            3'd6:    m = 16'd3511;
            default: m = 16'd4096;
        endcase
        return m;
    endfunction

    // Magnitude of k * pi / 16 in Q12, k from 0 to 16.
    function automatic logic [15:0] phase_mag(input logic [4:0] k);
        logic [15:0] m;
        case (k)
            5'd0:    m = 16'd0;
            5'd1:    m = 16'd804;
            5'd2:    m = 16'd1608;
            5'd3:    m = 16'd2413;
            5'd4:    m = 16'd3217;
            5'd5:    m = 16'd4021;
            5'd6:    m = 16'd4825;
            5'd7:    m = 16'd5630;
            5'd8:    m = 16'd6434;
            5'd9:    m = 16'd7238;
            5'd10:   m = 16'd8042;
            5'd11:   m = 16'd8847;
            5'd12:   m = 16'd9651;
            5'd13:   m = 16'd10455;
            5'd14:   m = 16'd11259;
            5'd15:   m = 16'd12064;
            default: m = 16'd12868;
        endcase
        return m;
    endfunction

    // Dequantised value of a code, signed Q12; zero for non-code results.
    function automatic logic signed [16:0] level_of(input logic [2:0] item_type,
                                                    input logic [4:0] code);
        logic [15:0]        mag;
        logic               neg;
        logic signed [16:0] pos;
        mag = 16'd0;
        neg = 1'b0;
        case (item_type)
            ITEM_INTENSITY:
            begin
                mag = code[4] ? intensity_mag(code[3:0]) : intensity_mag(~code[3:0]);
                neg = !code[4];
            end
            ITEM_COHERENCE:
            begin
                mag = coherence_val(code[2:0]);
            end
            ITEM_PHASE:
            begin
                mag = code[4] ? phase_mag({1'b0, code[3:0]})
                              : phase_mag(5'd16 - code);
                neg = !code[4];
            end
            default:
            begin
                mag = 16'd0;
            end
        endcase
        pos = $signed({1'b0, mag});
        return neg ? -pos : pos;
    endfunction

endpackage

`default_nettype wire

// ===== src/spu_front.sv =====
// ----------------------------------------------------------------------------
// spu_front
// Accepts frame bytes, tracks the frame and lists the results of each item.
// ----------------------------------------------------------------------------
`default_nettype none

module spu_front (
    input  wire logic             clk,
    input  wire logic             rst_n,
    input  wire logic             in_valid,
    output logic                  in_ready,
    input  wire logic [7:0]       data_byte,
    input  wire logic             frame_end,
    input  wire spu_pkg::qstat_t  qstat,
    output logic                  push,
    output spu_pkg::bundle_t      bundle
);

    // Frame parser states.
    localparam logic [2:0] ST_HEADER    = 3'd0;
    localparam logic [2:0] ST_INTENSITY = 3'd1;
    localparam logic [2:0] ST_COHERENCE = 3'd2;
    localparam logic [2:0] ST_PHASE     = 3'd3;
    localparam logic [2:0] ST_DONE      = 3'd4;

    logic [2:0]  state_reg, state_next;
    logic [4:0]  band_reg, band_next;
    logic [11:0] store_reg, store_next;
    logic [3:0]  level_reg, level_next;
    logic [4:0]  bands_reg, bands_next;
    logic        pflag_reg, pflag_next;
    logic        skip_reg, skip_next;

    logic        accept;

    assign in_ready = !qstat.full;
    assign accept   = in_valid && in_ready;

    // Work out the results of this byte and the frame state it leaves.
    always_comb
    begin
        logic [2:0]  n;
        logic [2:0]  width;
        logic [11:0] shifted;
        logic [4:0]  code;

        state_next = state_reg;
        band_next  = band_reg;
        store_next = store_reg;
        level_next = level_reg;
        bands_next = bands_reg;
        pflag_next = pflag_reg;
        skip_next  = skip_reg;
        n          = 3'd0;
        width      = 3'd5;
        shifted    = 12'd0;
        code       = 5'd0;
        bundle     = '0;

        if (skip_reg)
        begin
            // Rest of a rejected frame is dropped.
            if (frame_end)
            begin
                state_next = ST_HEADER;
                band_next  = 5'd0;
                store_next = 12'd0;
                level_next = 4'd0;
                skip_next  = 1'b0;
            end
        end
        else if (state_reg == ST_HEADER)
        begin
            store_next = 12'd0;
            level_next = 4'd0;
            band_next  = 5'd0;
            bands_next = data_byte[7:3];
            pflag_next = data_byte[2];
            bundle.ent[0] = '{spu_pkg::ITEM_HEADER, 5'd0, 5'd0, spu_pkg::FAULT_NONE};
            n = 3'd1;
            if (data_byte[7:3] == 5'd0 || data_byte[7:3] > 5'(spu_pkg::MAX_BANDS))
            begin
                bundle.ent[1] = '{spu_pkg::ITEM_ERROR, 5'd0, 5'd0, spu_pkg::FAULT_BAD_BANDS};
                n = 3'd2;
                if (!frame_end)
                begin
                    skip_next = 1'b1;
                end
            end
            else if (frame_end)
            begin
                bundle.ent[1] = '{spu_pkg::ITEM_ERROR, 5'd0, 5'd0, spu_pkg::FAULT_TRUNCATED};
                n = 3'd2;
            end
            else
            begin
                state_next = ST_INTENSITY;
            end
        end
        else if (state_reg == ST_DONE)
        begin
            // Padding and surplus bytes after the last code.
            if (frame_end)
            begin
                state_next = ST_HEADER;
                band_next  = 5'd0;
                store_next = 12'd0;
                level_next = 4'd0;
                skip_next  = 1'b0;
            end
        end
        else
        begin
            store_next = {store_reg[3:0], data_byte};
            level_next = level_reg + 4'd8;
            // At most three codes fit in the twelve buffered bits.
            for (int i = 0; i < 3; i++)
            begin
                width = (state_next == ST_COHERENCE) ? 3'd3 : 3'd5;
                if (state_next != ST_DONE && level_next >= {1'b0, width})
                begin
                    shifted = store_next >> (level_next - {1'b0, width});
                    code = shifted[4:0] & ((width == 3'd3) ? 5'h07 : 5'h1F);
                    level_next = level_next - {1'b0, width};
                    store_next = store_next & ~(12'hFFF << level_next);
                    bundle.ent[n[1:0]] = '{state_next, band_next, code, spu_pkg::FAULT_NONE};
                    n = n + 3'd1;
                    band_next = band_next + 5'd1;
                    if (band_next >= bands_next)
                    begin
                        band_next = 5'd0;
                        if (state_next == ST_INTENSITY)
                        begin
                            state_next = ST_COHERENCE;
                        end
                        else if (state_next == ST_COHERENCE && pflag_next)
                        begin
                            state_next = ST_PHASE;
                        end
                        else
                        begin
                            state_next = ST_DONE;
                            store_next = 12'd0;
                            level_next = 4'd0;
                            bundle.ent[n[1:0]] = '{spu_pkg::ITEM_COMPLETE, 5'd0, 5'd0,
                                                   spu_pkg::FAULT_NONE};
                            n = n + 3'd1;
                        end
                    end
                end
            end
            if (frame_end)
            begin
                if (state_next != ST_DONE)
                begin
                    bundle.ent[n[1:0]] = '{spu_pkg::ITEM_ERROR, 5'd0, 5'd0,
                                           spu_pkg::FAULT_TRUNCATED};
                    n = n + 3'd1;
                end
                state_next = ST_HEADER;
                band_next  = 5'd0;
                store_next = 12'd0;
                level_next = 4'd0;
                skip_next  = 1'b0;
            end
        end

        bundle.count      = n;
        bundle.band_total = bands_next;
        bundle.phase_flag = pflag_next;
    end

    assign push = accept && (bundle.count != 3'd0);

    // Frame state registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_HEADER;
            band_reg  <= 5'd0;
            store_reg <= 12'd0;
            level_reg <= 4'd0;
            bands_reg <= 5'd0;
            pflag_reg <= 1'b0;
            skip_reg  <= 1'b0;
        end
        else if (accept)
        begin
            state_reg <= state_next;
            band_reg  <= band_next;
            store_reg <= store_next;
            level_reg <= level_next;
            bands_reg <= bands_next;
            pflag_reg <= pflag_next;
            skip_reg  <= skip_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/spu_queue.sv =====
// ----------------------------------------------------------------------------
// spu_queue
// Short queue of result bundles between the front and back parts.
// ----------------------------------------------------------------------------
`default_nettype none

module spu_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire spu_pkg::bundle_t  wr_data,
    input  wire logic              pop,
    output spu_pkg::bundle_t       rd_data,
    output spu_pkg::qstat_t        qstat
);

    spu_pkg::bundle_t                slot_reg [spu_pkg::QUEUE_DEPTH];
    logic [spu_pkg::QPTR_W-1:0]      wr_ptr_reg, wr_ptr_next;
    logic [spu_pkg::QPTR_W-1:0]      rd_ptr_reg, rd_ptr_next;
    logic [spu_pkg::QCNT_W-1:0]      cnt_reg, cnt_next;

    assign qstat.full  = (cnt_reg == spu_pkg::QCNT_W'(spu_pkg::QUEUE_DEPTH));
    assign qstat.empty = (cnt_reg == '0);
    assign rd_data     = slot_reg[rd_ptr_reg];

    // Pointer and fill count updates, wrapping at the queue depth.
    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == spu_pkg::QPTR_W'(spu_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == spu_pkg::QPTR_W'(spu_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            cnt_next = cnt_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            cnt_next = cnt_reg - 1'b1;
        end
    end

    // Storage slots hold payload only.
    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= wr_data;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

endmodule

`default_nettype wire

// ===== src/spu_back.sv =====
// ----------------------------------------------------------------------------
// spu_back
// Issues the results of each bundle one per cycle while the receiver is ready, with their levels.
// ----------------------------------------------------------------------------
`default_nettype none

module spu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire spu_pkg::bundle_t  head,
    input  wire spu_pkg::qstat_t   qstat,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [2:0]             item_type,
    output logic [4:0]             band_index,
    output logic [4:0]             raw_code,
    output logic signed [16:0]     level_value,
    output logic [4:0]             band_total,
    output logic                   phase_present,
    output logic [1:0]             fault_code,
    output logic                   last_of_run
);

    logic [1:0]         idx_reg, idx_next;
    logic               valid_reg, valid_next;
    logic [2:0]         type_reg;
    logic [4:0]         band_reg;
    logic [4:0]         code_reg;
    logic signed [16:0] level_reg;
    logic [4:0]         total_reg;
    logic               pflag_reg;
    logic [1:0]         fault_reg;
    logic               last_reg;

    logic               load;
    logic               last_ent;
    spu_pkg::entry_t    cur;

    // Load the output register whenever it is free or being emptied.
    assign load     = !qstat.empty && (!valid_reg || out_ready);
    assign cur      = head.ent[idx_reg];
    assign last_ent = (idx_reg == 2'(head.count - 3'd1));
    assign pop      = load && last_ent;

    always_comb
    begin
        idx_next   = idx_reg;
        valid_next = valid_reg;
        if (load)
        begin
            valid_next = 1'b1;
            idx_next   = last_ent ? 2'd0 : idx_reg + 2'd1;
        end
        else if (out_ready)
        begin
            valid_next = 1'b0;
        end
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            idx_reg   <= 2'd0;
            valid_reg <= 1'b0;
        end
        else
        begin
            idx_reg   <= idx_next;
            valid_reg <= valid_next;
        end
    end

    // Output payload register; the level comes from the constant tables.
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            type_reg  <= cur.item_type;
            band_reg  <= cur.band;
            code_reg  <= cur.code;
            level_reg <= spu_pkg::level_of(cur.item_type, cur.code);
            total_reg <= head.band_total;
            pflag_reg <= head.phase_flag;
            fault_reg <= cur.fault;
            last_reg  <= last_ent;
        end
    end

    assign out_valid     = valid_reg;
    assign item_type     = type_reg;
    assign band_index    = band_reg;
    assign raw_code      = code_reg;
    assign level_value   = level_reg;
    assign band_total    = total_reg;
    assign phase_present = pflag_reg;
    assign fault_code    = fault_reg;
    assign last_of_run   = last_reg;

endmodule

`default_nettype wire

// ===== src/stereo_param_unpacker_core.sv =====
// ----------------------------------------------------------------------------
// stereo_param_unpacker_core
// Parametric stereo parameter frame unpacker, byte in, coded results out.
// ----------------------------------------------------------------------------
// Usage:
// Frame bytes enter on the in channel (data_byte, frame_end, in_valid and
// in_ready), header byte first, frame_end set on the final byte. Results
// leave on the out channel, one item per cycle while the receiver is ready,
// each with its type, band, code, Q12 level, header fields, fault and a
// last_of_run flag that marks the final result caused by a byte. Bytes
// that cause no result produce nothing on the out channel.
// The front part classifies one byte per cycle while the queue has room
// and queues its results (up to four); the back part issues one result per
// cycle from the queue while the receiver is ready. A byte's results are
// registered in the queue and then in the output register, from which the
// first is valid. Later bytes are taken while earlier results still wait.
// When the receiver stalls, the output register holds and the queue of two
// bundles fills; in_ready then falls until a bundle has been issued.
// Reset clears the frame parser to expect a header and empties the queue.
// ----------------------------------------------------------------------------
`default_nettype none

`include "stereo_param_unpacker_core_macros.svh"

module stereo_param_unpacker_core (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    output logic               in_ready,
    input  wire logic [7:0]    data_byte,
    input  wire logic          frame_end,
    output logic               out_valid,
    input  wire logic          out_ready,
    output logic [2:0]         item_type,
    output logic [4:0]         band_index,
    output logic [4:0]         raw_code,
    output logic signed [16:0] level_value,
    output logic [4:0]         band_total,
    output logic               phase_present,
    output logic [1:0]         fault_code,
    output logic               last_of_run
);

    spu_pkg::qstat_t  qstat;
    spu_pkg::bundle_t wr_bundle;
    spu_pkg::bundle_t rd_bundle;
    logic             push;
    logic             pop;

    // Front part: byte parsing and classification.
    spu_front u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .data_byte (data_byte),
        .frame_end (frame_end),
        .qstat     (qstat),
        .push      (push),
        .bundle    (wr_bundle)
    );

    // Queue of result bundles.
    spu_queue u_queue (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (wr_bundle),
        .pop     (pop),
        .rd_data (rd_bundle),
        .qstat   (qstat)
    );

    // Back part: result issue and dequantisation.
    spu_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head          (rd_bundle),
        .qstat         (qstat),
        .pop           (pop),
        .out_valid     (out_valid),
        .out_ready     (out_ready),
        .item_type     (item_type),
        .band_index    (band_index),
        .raw_code      (raw_code),
        .level_value   (level_value),
        .band_total    (band_total),
        .phase_present (phase_present),
        .fault_code    (fault_code),
        .last_of_run   (last_of_run)
    );

    // The queue is never full and empty together, and never popped when empty.
    `SPU_ASSERT_NOW(a_qstat_sane, 1'b1, !(qstat.full && qstat.empty), "queue status inconsistent")
    `SPU_ASSERT_NOW(a_pop_nonempty, pop, !qstat.empty, "pop from empty queue")
    // A full queue with no pop stays full.
    `SPU_ASSERT_NEXT(a_full_holds, qstat.full && !pop, qstat.full, "full queue lost an item")
    // Faults only travel on error results.
    `SPU_ASSERT_NOW(a_fault_type, out_valid && (item_type != spu_pkg::ITEM_ERROR),
                    fault_code == spu_pkg::FAULT_NONE, "fault on a non-error result")

endmodule

`default_nettype wire
